>>> rtl/lfrc_pkg.sv
// Shared types and constants of the link frame receive checker.
`default_nettype none
package lfrc_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ID     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BROADCAST_ID = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_MASK     = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN      = 8'd3;

	// Verdict codes, in priority order after ok.
	localparam logic [2:0] VERD_OK     = 3'd0;
	localparam logic [2:0] VERD_SHORT  = 3'd1;
	localparam logic [2:0] VERD_NOADDR = 3'd2;
	localparam logic [2:0] VERD_LEN    = 3'd3;
	localparam logic [2:0] VERD_CRC    = 3'd4;

	// Result kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Frame layout and CRC-16 constants.
	localparam int          HDR_BYTES = 7;
	localparam int          MIN_FRAME = 9;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'h1021;

	// Queue between the classifying front and the output back.
	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic [15:0] local_id;
		logic [15:0] broadcast_id;
		logic [7:0]  ack_mask;
		logic [7:0]  max_len;
	} cfg_t;

	// One classified request: a payload byte or the raw facts for a verdict.
	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic        too_short;
		logic        not_addr;
		logic        len_bad;
		logic        crc_bad;
		logic [15:0] sender;
		logic [7:0]  seq;
		logic [7:0]  len;
		logic        ack;
	} entry_t;

endpackage
`default_nettype wire

>>> rtl/link_frame_receive_checker_top.sv
// Top level of the link frame receive checker: configuration registers and the three parts.
//
// The checker takes one received frame byte per request on the input channel, frame_end
// marking the last byte, and returns payload bytes of frames addressed to this node (local
// or broadcast address, at most max_len per frame) followed by one verdict per frame: ok,
// too short, not addressed, length mismatch or CRC error (CRC-16-CCITT, poly 0x1021, init
// 0xFFFF, sent big-endian). Forwarded bytes are tentative and are never withdrawn when the
// verdict is bad. The block sustains one byte per clock cycle: the front part updates the
// header fields, byte count and CRC for a whole byte at once, and a two-entry queue
// feeds the output register, so in_ready only drops when that queue is full because the
// consumer holds out_ready low. A payload byte or verdict passes through the queue and
// then the output register on its way out. Configuration writes are always accepted
// (cfg_ready is tied high) and must only happen while no frame is in flight; writes to an
// index beyond max_len are ignored.
`default_nettype none
module link_frame_receive_checker_top #(
	parameter int MAX_FRAME_BYTES = 264
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [lfrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [15:0]                    cfg_data,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [7:0]                     rx_byte,
	input  wire                            frame_end,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic                           item_kind,
	output logic [7:0]                     payload_byte,
	output logic [2:0]                     verdict,
	output logic [15:0]                    sender_id,
	output logic [7:0]                     sequence_res,
	output logic [7:0]                     payload_count,
	output logic                           ack_needed,
	output logic                           is_last
);

	lfrc_pkg::cfg_t   cfg_q;
	lfrc_pkg::entry_t push_entry, pop_entry;
	logic             push, pop, q_full, q_empty;

	// Configuration registers; the port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_id     <= 16'h0000;
			cfg_q.broadcast_id <= 16'hFFFF;
			cfg_q.ack_mask     <= 8'h01;
			cfg_q.max_len      <= 8'hFF;
		end else if (cfg_valid) begin
			case (cfg_index)
				lfrc_pkg::REG_LOCAL_ID:     cfg_q.local_id     <= cfg_data;
				lfrc_pkg::REG_BROADCAST_ID: cfg_q.broadcast_id <= cfg_data;
				lfrc_pkg::REG_ACK_MASK:     cfg_q.ack_mask     <= cfg_data[7:0];
				lfrc_pkg::REG_MAX_LEN:      cfg_q.max_len      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// The front classifies each accepted byte and queues a request when it yields a result.
	lfrc_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.frame_end  (frame_end),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	lfrc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.empty      (q_empty),
		.pop_entry  (pop_entry)
	);

	// The back resolves the verdict and drives the registered output channel.
	lfrc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_entry       (pop_entry),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.item_kind     (item_kind),
		.payload_byte  (payload_byte),
		.verdict       (verdict),
		.sender_id     (sender_id),
		.sequence_res  (sequence_res),
		.payload_count (payload_count),
		.ack_needed    (ack_needed),
		.is_last       (is_last)
	);

endmodule
`default_nettype wire

>>> rtl/lfrc_front.sv
// Front part: accepts frame bytes, tracks header, CRC and byte count, classifies each byte.
`default_nettype none
module lfrc_front #(
	parameter int MAX_FRAME_BYTES = 264
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lfrc_pkg::cfg_t      cfg,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [7:0]          rx_byte,
	input  wire                 frame_end,
	input  wire                 q_full,
	output logic                push,
	output lfrc_pkg::entry_t    push_entry
);

	localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 2);
	localparam int CMP_W = (IDX_W > 9) ? IDX_W + 1 : 10;
	localparam logic [IDX_W-1:0] IDX_SAT = IDX_W'(MAX_FRAME_BYTES + 1);

	// Byte-wide CRC-16 update, MSB first.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ lfrc_pkg::CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	logic [IDX_W-1:0] idx_q, idx_n;
	logic [15:0]      crc_q, crc_n;
	logic [15:0]      crcr_q, crcr_n;
	logic [15:0]      dest_q, dest_n;
	logic [15:0]      src_q, src_n;
	logic [7:0]       seq_q, seq_n;
	logic [7:0]       flags_q, flags_n;
	logic [7:0]       len_q, len_n;
	logic             accept, addressed, fwd;
	logic [CMP_W-1:0] i_w, n_w, len_w, ml_w;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		dest_n  = dest_q;
		src_n   = src_q;
		seq_n   = seq_q;
		flags_n = flags_q;
		len_n   = len_q;
		case (idx_q)
			IDX_W'(0): dest_n  = {rx_byte, dest_q[7:0]};
			IDX_W'(1): dest_n  = {dest_q[15:8], rx_byte};
			IDX_W'(2): src_n   = {rx_byte, src_q[7:0]};
			IDX_W'(3): src_n   = {src_q[15:8], rx_byte};
			IDX_W'(4): seq_n   = rx_byte;
			IDX_W'(5): flags_n = rx_byte;
			IDX_W'(6): len_n   = rx_byte;
			default: ;
		endcase
		// The two newest bytes are held back; the older one enters the CRC.
		crc_n  = (idx_q >= IDX_W'(2)) ? crc_feed(crc_q, crcr_q[15:8]) : crc_q;
		crcr_n = {crcr_q[7:0], rx_byte};
		idx_n  = (idx_q < IDX_SAT) ? idx_q + IDX_W'(1) : idx_q;

		addressed = (dest_n == cfg.local_id) || (dest_n == cfg.broadcast_id);
		i_w   = CMP_W'(idx_q);
		n_w   = CMP_W'(idx_n);
		len_w = CMP_W'(len_n);
		ml_w  = CMP_W'(cfg.max_len);

		// Payload window, capped by the length field, max_len and the frame size limit.
		fwd = !frame_end && addressed
			&& (i_w >= CMP_W'(lfrc_pkg::HDR_BYTES))
			&& (i_w < CMP_W'(MAX_FRAME_BYTES))
			&& (i_w <= len_w + CMP_W'(lfrc_pkg::HDR_BYTES - 1))
			&& (i_w < ml_w + CMP_W'(lfrc_pkg::HDR_BYTES));

		push = accept && (frame_end || fwd);

		push_entry.kind      = frame_end ? lfrc_pkg::KIND_VERDICT : lfrc_pkg::KIND_PAYLOAD;
		push_entry.data      = frame_end ? 8'h00 : rx_byte;
		push_entry.too_short = n_w < CMP_W'(lfrc_pkg::MIN_FRAME);
		push_entry.not_addr  = !addressed;
		push_entry.len_bad   = (n_w != len_w + CMP_W'(lfrc_pkg::MIN_FRAME))
			|| (n_w > CMP_W'(MAX_FRAME_BYTES));
		push_entry.crc_bad   = crc_n != crcr_n;
		push_entry.sender    = src_n;
		push_entry.seq       = seq_n;
		push_entry.len       = len_n;
		push_entry.ack       = ((flags_n & cfg.ack_mask) != 8'h00) && (dest_n == cfg.local_id);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			crc_q   <= lfrc_pkg::CRC_INIT;
			crcr_q  <= '0;
			dest_q  <= '0;
			src_q   <= '0;
			seq_q   <= '0;
			flags_q <= '0;
			len_q   <= '0;
		end else if (accept) begin
			if (frame_end) begin
				idx_q   <= '0;
				crc_q   <= lfrc_pkg::CRC_INIT;
				crcr_q  <= '0;
				dest_q  <= '0;
				src_q   <= '0;
				seq_q   <= '0;
				flags_q <= '0;
				len_q   <= '0;
			end else begin
				idx_q   <= idx_n;
				crc_q   <= crc_n;
				crcr_q  <= crcr_n;
				dest_q  <= dest_n;
				src_q   <= src_n;
				seq_q   <= seq_n;
				flags_q <= flags_n;
				len_q   <= len_n;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/lfrc_queue.sv
// Short request queue between the front and back parts.
`default_nettype none
module lfrc_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  lfrc_pkg::entry_t    push_entry,
	output logic                full,
	input  wire                 pop,
	output logic                empty,
	output lfrc_pkg::entry_t    pop_entry
);

	localparam int PTR_W = $clog2(lfrc_pkg::Q_DEPTH);
	localparam int CNT_W = $clog2(lfrc_pkg::Q_DEPTH + 1);

	lfrc_pkg::entry_t mem_q [lfrc_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full      = cnt_q == CNT_W'(lfrc_pkg::Q_DEPTH);
	assign empty     = cnt_q == '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign pop_entry = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(lfrc_pkg::Q_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(lfrc_pkg::Q_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/lfrc_back.sv
// Back part: resolves verdict priority and holds the result in the output register.
`default_nettype none
module lfrc_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_empty,
	input  lfrc_pkg::entry_t    q_entry,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic                item_kind,
	output logic [7:0]          payload_byte,
	output logic [2:0]          verdict,
	output logic [15:0]         sender_id,
	output logic [7:0]          sequence_res,
	output logic [7:0]          payload_count,
	output logic                ack_needed,
	output logic                is_last
);

	logic        valid_q;
	logic        kind_q, last_q, ack_q;
	logic [7:0]  byte_q, seq_q, len_q;
	logic [2:0]  verd_q;
	logic [15:0] sender_q;
	logic [2:0]  verd_c;
	logic        ok_c;

	assign pop = !q_empty && (!valid_q || out_ready);

	always_comb begin
		if (q_entry.kind == lfrc_pkg::KIND_PAYLOAD) begin
			verd_c = lfrc_pkg::VERD_OK;
		end else if (q_entry.too_short) begin
			verd_c = lfrc_pkg::VERD_SHORT;
		end else if (q_entry.not_addr) begin
			verd_c = lfrc_pkg::VERD_NOADDR;
		end else if (q_entry.len_bad) begin
			verd_c = lfrc_pkg::VERD_LEN;
		end else if (q_entry.crc_bad) begin
			verd_c = lfrc_pkg::VERD_CRC;
		end else begin
			verd_c = lfrc_pkg::VERD_OK;
		end
		ok_c = (q_entry.kind == lfrc_pkg::KIND_VERDICT) && (verd_c == lfrc_pkg::VERD_OK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= q_entry.kind;
			last_q   <= q_entry.kind == lfrc_pkg::KIND_VERDICT;
			byte_q   <= q_entry.data;
			verd_q   <= verd_c;
			sender_q <= ok_c ? q_entry.sender : 16'h0000;
			seq_q    <= ok_c ? q_entry.seq : 8'h00;
			len_q    <= ok_c ? q_entry.len : 8'h00;
			ack_q    <= ok_c && q_entry.ack;
		end
	end

	assign out_valid     = valid_q;
	assign item_kind     = kind_q;
	assign payload_byte  = byte_q;
	assign verdict       = verd_q;
	assign sender_id     = sender_q;
	assign sequence_res  = seq_q;
	assign payload_count = len_q;
	assign ack_needed    = ack_q;
	assign is_last       = last_q;

endmodule
`default_nettype wire

>>> rtl/lfrc_checker.sv
// Port-level assertions for the link frame receive checker, bound to the top level.
`default_nettype none
module lfrc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_ready,
	input wire        item_kind,
	input wire [7:0]  payload_byte,
	input wire [2:0]  verdict,
	input wire [15:0] sender_id,
	input wire [7:0]  sequence_res,
	input wire [7:0]  payload_count,
	input wire        ack_needed,
	input wire        is_last
);

	// A stalled result keeps its kind, byte, verdict and sender.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(item_kind)
			&& $stable(payload_byte) && $stable(verdict) && $stable(sender_id))
		else $error("result changed while stalled");

	// Payload items carry no verdict information.
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (item_kind == lfrc_pkg::KIND_PAYLOAD) |->
			!is_last && (verdict == lfrc_pkg::VERD_OK) && (sender_id == 16'h0000)
			&& (payload_count == 8'h00) && !ack_needed)
		else $error("payload item carries verdict fields");

	// A verdict item ends the frame and payload_byte is zero.
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (item_kind == lfrc_pkg::KIND_VERDICT) |->
			is_last && (payload_byte == 8'h00))
		else $error("verdict item not marked last");

	// Header fields are reported only on a good frame.
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (verdict != lfrc_pkg::VERD_OK) |->
			(sender_id == 16'h0000) && (sequence_res == 8'h00)
			&& (payload_count == 8'h00) && !ack_needed)
		else $error("bad verdict carries header fields");

endmodule

bind link_frame_receive_checker_top lfrc_checker u_lfrc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.item_kind     (item_kind),
	.payload_byte  (payload_byte),
	.verdict       (verdict),
	.sender_id     (sender_id),
	.sequence_res  (sequence_res),
	.payload_count (payload_count),
	.ack_needed    (ack_needed),
	.is_last       (is_last)
);
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the link frame receive checker, with its frame predictor.
module tb_top;

	localparam int FRAME_MAX     = 264;  // longest frame the block counts
	localparam int CLK_HALF      = 4;    // 8 ns period
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 12;   // generous margin against the output latency
	localparam int QUIET_LIMIT   = 1000; // cycles with no handshake before giving up
	localparam int RANDOM_BYTES  = 200;  // on top of the directed frames, about 850 in all
	localparam int PHASES        = 4;

	// An index past the register list; the block must ignore writes to it.
	localparam logic [lfrc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd200;

	// One result request as seen on the output channel.
	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [2:0]  verdict;
		logic [15:0] sender;
		logic [7:0]  seq;
		logic [7:0]  count;
		logic        ack;
		logic        last;
	} rx_result_t;

	// Tracks the frame being received, works out the payload bytes and verdicts that each
	// accepted byte must produce, and checks the output against them in order.
	class rx_frame_tracker;
		lfrc_pkg::cfg_t cfg;
		logic [8:0]     byte_count;
		logic [15:0]    crc_calc;
		logic [15:0]    crc_tail;
		logic [15:0]    dest;
		logic [15:0]    src;
		logic [7:0]     seq_f;
		logic [7:0]     flags_f;
		logic [7:0]     len_f;
		rx_result_t     rx_items_due[$];
		int             fails;
		int             results_seen;

		function new();
			cfg.local_id     = 16'h0000;
			cfg.broadcast_id = 16'hFFFF;
			cfg.ack_mask     = 8'h01;
			cfg.max_len      = 8'hFF;
			fails            = 0;
			results_seen     = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			byte_count = '0;
			crc_calc   = lfrc_pkg::CRC_INIT;
			crc_tail   = '0;
			dest       = '0;
			src        = '0;
			seq_f      = '0;
			flags_f    = '0;
			len_f      = '0;
		endfunction

		function void write_reg(logic [lfrc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
			case (idx)
				lfrc_pkg::REG_LOCAL_ID:     cfg.local_id     = data;
				lfrc_pkg::REG_BROADCAST_ID: cfg.broadcast_id = data;
				lfrc_pkg::REG_ACK_MASK:     cfg.ack_mask     = data[7:0];
				lfrc_pkg::REG_MAX_LEN:      cfg.max_len      = data[7:0];
				default:          ;
			endcase
		endfunction

		// CRC-16-CCITT, MSB first, one byte.
		function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			r = c ^ {b, 8'h00};
			for (int k = 0; k < 8; k++)
				r = r[15] ? ((r << 1) ^ lfrc_pkg::CRC_POLY) : (r << 1);
			return r;
		endfunction

		function void predict_byte(logic [7:0] b, logic last);
			int         pos;
			int         n;
			bit         hit;
			logic [2:0] v;
			rx_result_t r;
			pos = byte_count;
			case (pos)
				0: dest[15:8] = b;
				1: dest[7:0]  = b;
				2: src[15:8]  = b;
				3: src[7:0]   = b;
				4: seq_f      = b;
				5: flags_f    = b;
				6: len_f      = b;
				default: ;
			endcase
			// The last two bytes are held back as the candidate CRC; older ones are folded in.
			if (pos >= 2)
				crc_calc = crc_byte(crc_calc, crc_tail[15:8]);
			crc_tail = {crc_tail[7:0], b};
			if (byte_count < FRAME_MAX + 1)
				byte_count = byte_count + 1'b1;
			hit = (dest == cfg.local_id) || (dest == cfg.broadcast_id);
			r = '0;
			if (!last) begin
				if (pos >= lfrc_pkg::HDR_BYTES && pos < FRAME_MAX &&
				    pos < lfrc_pkg::HDR_BYTES + int'(len_f) &&
				    pos - lfrc_pkg::HDR_BYTES < int'(cfg.max_len) && hit) begin
					r.kind = lfrc_pkg::KIND_PAYLOAD;
					r.data = b;
					rx_items_due.push_back(r);
				end
			end else begin
				n = byte_count;
				if (n < lfrc_pkg::MIN_FRAME)
					v = lfrc_pkg::VERD_SHORT;
				else if (!hit)
					v = lfrc_pkg::VERD_NOADDR;
				else if (n != int'(len_f) + lfrc_pkg::MIN_FRAME || n > FRAME_MAX)
					v = lfrc_pkg::VERD_LEN;
				else if (crc_tail != crc_calc)
					v = lfrc_pkg::VERD_CRC;
				else
					v = lfrc_pkg::VERD_OK;
				r.kind    = lfrc_pkg::KIND_VERDICT;
				r.last    = 1'b1;
				r.verdict = v;
				if (v == lfrc_pkg::VERD_OK) begin
					r.sender = src;
					r.seq    = seq_f;
					r.count  = len_f;
					r.ack    = ((flags_f & cfg.ack_mask) != 0) && (dest == cfg.local_id);
				end
				rx_items_due.push_back(r);
				clear_frame();
			end
		endfunction

		task report(string msg);
			$display("[%0t] mismatch at result %0d: %s", $realtime, results_seen, msg);
			fails++;
		endtask

		task compare_field(string name, logic [15:0] got_v, logic [15:0] want_v);
			if (got_v !== want_v)
				report($sformatf("%s is %0h, expected %0h", name, got_v, want_v));
		endtask

		task check_result(rx_result_t got);
			rx_result_t want;
			results_seen++;
			if (rx_items_due.size() == 0) begin
				report($sformatf("unexpected result, kind %0d byte %0h verdict %0d",
					got.kind, got.data, got.verdict));
				return;
			end
			want = rx_items_due.pop_front();
			compare_field("item_kind", got.kind, want.kind);
			compare_field("payload_byte", got.data, want.data);
			compare_field("verdict", got.verdict, want.verdict);
			compare_field("sender_id", got.sender, want.sender);
			compare_field("sequence_res", got.seq, want.seq);
			compare_field("payload_count", got.count, want.count);
			compare_field("ack_needed", got.ack, want.ack);
			compare_field("is_last", got.last, want.last);
		endtask
	endclass

	// Every input of the block has a known value from time zero.
	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic [lfrc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]                    cfg_data  = '0;
	logic                           in_valid  = 1'b0;
	logic [7:0]                     rx_byte   = '0;
	logic                           frame_end = 1'b0;
	logic                           out_ready = 1'b0;

	logic       cfg_ready;
	logic       in_ready;
	logic       out_valid;
	logic       item_kind;
	logic [7:0] payload_byte;
	logic [2:0] verdict;
	logic [15:0] sender_id;
	logic [7:0] sequence_res;
	logic [7:0] payload_count;
	logic       ack_needed;
	logic       is_last;

	rx_frame_tracker tracker;
	logic [7:0]      frame_q[$];   // bytes of the frame about to be sent
	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;
	int              quiet_cycles = 0;

	link_frame_receive_checker_top #(
		.MAX_FRAME_BYTES(FRAME_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_kind(item_kind),
		.payload_byte(payload_byte),
		.verdict(verdict),
		.sender_id(sender_id),
		.sequence_res(sequence_res),
		.payload_count(payload_count),
		.ack_needed(ack_needed),
		.is_last(is_last)
	);

	always #CLK_HALF clk = ~clk;

	// Output side. Everything is sampled right at the rising edge, before any nonblocking
	// update of that edge lands, so a request counts exactly when valid and ready were both
	// high going into the edge. The same block stalls the receiver at random and keeps the
	// count of cycles in which no request of any channel went through.
	always @(posedge clk) begin : out_side
		rx_result_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.kind    = item_kind;
				got.data    = payload_byte;
				got.verdict = verdict;
				got.sender  = sender_id;
				got.seq     = sequence_res;
				got.count   = payload_count;
				got.ack     = ack_needed;
				got.last    = is_last;
				tracker.check_result(got);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// A hung handshake ends the run here.
	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// One configuration write. Valid drops for a cycle afterwards, so two writes in a row
	// never put two assignments on cfg_valid within one time step.
	task write_reg(logic [lfrc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// The 8-bit registers get random upper data bits, which the block must drop. A write to
	// an index past the list follows and must change nothing.
	task set_config(logic [15:0] local_v, logic [15:0] bcast_v, logic [7:0] mask_v,
	                logic [7:0] maxl_v);
		write_reg(lfrc_pkg::REG_LOCAL_ID, local_v);
		write_reg(lfrc_pkg::REG_BROADCAST_ID, bcast_v);
		write_reg(lfrc_pkg::REG_ACK_MASK, {8'($urandom_range(255)), mask_v});
		write_reg(lfrc_pkg::REG_MAX_LEN, {8'($urandom_range(255)), maxl_v});
		write_reg(REG_UNUSED, 16'($urandom_range(65535)));
	endtask

	// Lets the block run dry before registers change. Input valid falls in the step in which
	// the last byte was taken, which is the only assignment to it in that step.
	task settle();
		in_valid <= 1'b0;
		while (tracker.rx_items_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offers one byte. Idle cycles come first and at random; once valid is up it stays up
	// with the same byte until the request goes through.
	task send_byte(logic [7:0] b, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		rx_byte   <= b;
		frame_end <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.predict_byte(b, last);
	endtask

	task send_frame();
		foreach (frame_q[k])
			send_byte(frame_q[k], k == frame_q.size() - 1);
	endtask

	// Builds a frame whose length field says len_v but which carries npay payload bytes. The
	// CRC covers the header and payload bytes actually sent; crc_flip spoils it where nonzero.
	task make_frame(logic [15:0] dest, logic [15:0] src, logic [7:0] seq_v,
	                logic [7:0] flags_v, logic [7:0] len_v, int npay, logic [15:0] crc_flip);
		logic [15:0] c;
		frame_q.delete();
		frame_q.push_back(dest[15:8]);
		frame_q.push_back(dest[7:0]);
		frame_q.push_back(src[15:8]);
		frame_q.push_back(src[7:0]);
		frame_q.push_back(seq_v);
		frame_q.push_back(flags_v);
		frame_q.push_back(len_v);
		for (int k = 0; k < npay; k++)
			frame_q.push_back(8'($urandom_range(255)));
		c = lfrc_pkg::CRC_INIT;
		foreach (frame_q[k])
			c = tracker.crc_byte(c, frame_q[k]);
		c = c ^ crc_flip;
		frame_q.push_back(c[15:8]);
		frame_q.push_back(c[7:0]);
	endtask

	// Random bytes with no frame structure at all.
	task make_noise(int n);
		frame_q.delete();
		for (int k = 0; k < n; k++)
			frame_q.push_back(8'($urandom_range(255)));
	endtask

	// Hand-picked frames under the reset register values: local address 0, broadcast all
	// ones, acknowledgement on flag bit 0, up to 255 bytes forwarded.
	task run_directed();
		// Good unicast frame that asks for an acknowledgement.
		make_frame(16'h0000, 16'h1234, 8'h01, 8'h01, 8'd2, 2, 16'h0000);
		send_frame();
		// Good broadcast frame with every address, sequence and flag bit set: no acknowledgement.
		make_frame(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'd1, 1, 16'h0000);
		send_frame();
		// Unicast frame with the acknowledgement bit clear and no payload: shortest good frame.
		make_frame(16'h0000, 16'h0000, 8'h00, 8'hFE, 8'd0, 0, 16'h0000);
		send_frame();
		// Frame for another node, bad length and CRC too: the address check wins.
		make_frame(16'h8000, 16'h00FF, 8'h80, 8'h01, 8'd2, 3, 16'h0101);
		send_frame();
		// A single byte that is already the end, then a frame one byte too short.
		make_noise(1);
		send_frame();
		make_noise(8);
		send_frame();
		// Length field larger than the payload, then smaller with a bad CRC as well.
		make_frame(16'h0000, 16'hA5A5, 8'h5A, 8'h00, 8'd3, 2, 16'h0000);
		send_frame();
		make_frame(16'h0000, 16'h5A5A, 8'hA5, 8'h01, 8'd5, 6, 16'h8000);
		send_frame();
		// Good length, corrupted CRC.
		make_frame(16'h0000, 16'h0F0F, 8'h33, 8'h01, 8'd4, 4, 16'h0001);
		send_frame();
		// Largest good frame, then one that runs past the most bytes the block counts.
		make_frame(16'h0000, 16'h4321, 8'h7E, 8'h01, 8'd255, 255, 16'h0000);
		send_frame();
		make_frame(16'hFFFF, 16'h1111, 8'h11, 8'h01, 8'd255, 257, 16'h0000);
		send_frame();
	endtask

	// Mostly well-formed frames with random content aimed at this node or at broadcast, the
	// rest damaged in one way or another, or plain noise.
	task run_random(int budget);
		int          sent;
		int          r;
		int          len;
		int          npay;
		logic [15:0] dest;
		sent = 0;
		while (sent < budget) begin
			r = $urandom_range(99);
			if (r < 45)
				dest = tracker.cfg.local_id;
			else if (r < 70)
				dest = tracker.cfg.broadcast_id;
			else if (r < 85)
				dest = 16'($urandom_range(65535));
			else
				dest = tracker.cfg.local_id ^ (16'h0001 << $urandom_range(15));
			r = $urandom_range(99);
			len = (r < 3) ? $urandom_range(128, 255) : $urandom_range(0, 20);
			if (r < 68) begin
				make_frame(dest, 16'($urandom_range(65535)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'(len), len, 16'h0000);
			end else if (r < 80) begin
				make_frame(dest, 16'($urandom_range(65535)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'(len), len, 16'($urandom_range(1, 65535)));
			end else if (r < 89) begin
				if ($urandom_range(1) == 0 && len > 0)
					npay = len - 1;
				else
					npay = len + $urandom_range(1, 3);
				make_frame(dest, 16'($urandom_range(65535)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'(len), npay, 16'h0000);
			end else if (r < 96) begin
				make_noise($urandom_range(1, lfrc_pkg::MIN_FRAME - 1));
			end else if (r < 99) begin
				make_noise($urandom_range(lfrc_pkg::MIN_FRAME, 40));
			end else begin
				make_frame(dest, 16'($urandom_range(65535)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'd255, $urandom_range(256, 262), 16'h0000);
			end
			send_frame();
			sent += frame_q.size();
		end
	endtask

	initial begin : main
		logic [15:0] addr;
		tracker = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Four phases: no idling, a sender that idles, a receiver that stalls, then both.
		// The first runs on reset values; each later one starts from new register values,
		// written only once the block has gone quiet.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					run_directed();
				end
				1: begin
					send_idle_pct  = 45;
					recv_stall_pct = 0;
					settle();
					// Extremes: all-ones node address, zero broadcast, nothing forwarded.
					set_config(16'hFFFF, 16'h0000, 8'hFF, 8'd0);
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 45;
					settle();
					// Broadcast equal to the node's own address, which still allows acks.
					addr = 16'($urandom_range(65535));
					set_config(addr, addr, 8'($urandom_range(1, 255)), 8'd3);
				end
				default: begin
					send_idle_pct  = 36;
					recv_stall_pct = 36;
					settle();
					// No flag bit asks for an acknowledgement.
					set_config(16'($urandom_range(65535)), 16'hFFFF, 8'h00,
						8'($urandom_range(1, 20)));
				end
			endcase
			run_random(RANDOM_BYTES / PHASES);
		end

		// Drain: everything predicted must arrive, and nothing more may follow.
		in_valid <= 1'b0;
		while (tracker.rx_items_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

>>> filelist.f
rtl/lfrc_pkg.sv
rtl/lfrc_front.sv
rtl/lfrc_queue.sv
rtl/lfrc_back.sv
rtl/link_frame_receive_checker_top.sv
rtl/lfrc_checker.sv
test/tb_top.sv
